>>> design/ole_pkg.sv
// Shared constants and types for the ordered list engine.
package ole_pkg;

   localparam int CAPACITY = 16;
   localparam int DATA_W   = 32;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   localparam int REQ_W    = 3;
   localparam int POS_W    = 5;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int FIDX_W   = 4;
   localparam int LEN_W    = 5;

   localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd0;
   localparam logic [REQ_W-1:0] REQ_INSERT = 3'd1;
   localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd2;
   localparam logic [REQ_W-1:0] REQ_SEARCH = 3'd3;
   localparam logic [REQ_W-1:0] REQ_READ   = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BOUND    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

   typedef enum logic [6:0] {
      S_IDLE     = 7'b0000001,
      S_SHIFT_UP = 7'b0000010,
      S_INS_PUT  = 7'b0000100,
      S_SHIFT_DN = 7'b0001000,
      S_SEARCH   = 7'b0010000,
      S_READ     = 7'b0100000,
      S_DONE     = 7'b1000000
   } state_type;

   typedef struct packed {
      logic [STATUS_W-1:0]       status;
      logic signed [VALUE_W-1:0] read_value;
      logic [FIDX_W-1:0]         found_index;
      logic [LEN_W-1:0]          list_length;
   } result_type;

endpackage

>>> design/ordered_list_engine_unit.sv
// Ordered list engine: list kept in a registered-read RAM, shifted one entry per cycle.
// Clear, rejected and unknown requests and tail insert/remove go straight to S_DONE;
// read passes S_READ; search walks entries from 0 up to a match or the tail in S_SEARCH;
// insert shifts entries up (S_SHIFT_UP), then writes (S_INS_PUT); remove shifts down.
// One transaction at a time: the RAM walk sets the rate; req_stall is high while busy.
// Synchronous reset empties the list and clears control; RAM contents are not cleared.
module ordered_list_engine_unit import ole_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [REQ_W-1:0]           req_type,
   input  logic [POS_W-1:0]           req_position,
   input  logic signed [VALUE_W-1:0]  req_value,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic signed [VALUE_W-1:0]  rsp_read_value,
   output logic [FIDX_W-1:0]          rsp_found_index,
   output logic [LEN_W-1:0]           rsp_list_length
);

   logic [DATA_W-1:0] entry_mem [CAPACITY];

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [IDX_W-1:0]    k_ff, k_in;
   logic [IDX_W-1:0]    pos_ff, pos_in;
   logic [DATA_W-1:0]   val_ff, val_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [DATA_W-1:0]   rdv_ff, rdv_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [DATA_W-1:0]   rd_data_ff;

   logic                rd_en;
   logic [IDX_W-1:0]    rd_addr;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   logic [DATA_W-1:0]   wr_data;

   logic [CNT_W-1:0]    count_m1;
   logic [IDX_W-1:0]    cnt_last;
   logic [IDX_W-1:0]    req_pos;
   logic [31:0]         pos_w;
   logic [31:0]         cnt_w;
   logic                res_load;
   logic                rsp_free;
   result_type          result;

   assign count_m1  = count_ff - CNT_W'(1);
   assign cnt_last  = count_m1[IDX_W-1:0];
   assign req_pos   = req_position[IDX_W-1:0];
   assign pos_w     = 32'(req_position);
   assign cnt_w     = 32'(count_ff);
   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      k_in      = k_ff;
      pos_in    = pos_ff;
      val_in    = val_ff;
      status_in = status_ff;
      rdv_in    = rdv_ff;
      idx_in    = idx_ff;
      rd_en     = 1'b0;
      rd_addr   = k_ff;
      wr_en     = 1'b0;
      wr_addr   = k_ff;
      wr_data   = rd_data_ff;
      res_load  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               pos_in    = req_pos;
               val_in    = DATA_W'(req_value);
               status_in = ST_OK;
               rdv_in    = '0;
               idx_in    = '0;
               state_in  = S_DONE;
               case (req_type)
                  REQ_CLEAR: begin
                     count_in = '0;
                  end
                  REQ_INSERT: begin
                     if (pos_w > cnt_w) begin
                        status_in = ST_BOUND;
                     end else if (cnt_w == 32'(CAPACITY)) begin
                        status_in = ST_FULL;
                     end else if (pos_w == cnt_w) begin
                        wr_en    = 1'b1;
                        wr_addr  = req_pos;
                        wr_data  = DATA_W'(req_value);
                        count_in = count_ff + CNT_W'(1);
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = cnt_last;
                        k_in     = cnt_last;
                        state_in = S_SHIFT_UP;
                     end
                  end
                  REQ_REMOVE: begin
                     if (pos_w >= cnt_w) begin
                        status_in = ST_BOUND;
                     end else if (req_pos == cnt_last) begin
                        count_in = count_m1;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = req_pos + IDX_W'(1);
                        k_in     = req_pos + IDX_W'(1);
                        state_in = S_SHIFT_DN;
                     end
                  end
                  REQ_SEARCH: begin
                     if (count_ff == '0) begin
                        status_in = ST_NOTFOUND;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = '0;
                        k_in     = '0;
                        state_in = S_SEARCH;
                     end
                  end
                  REQ_READ: begin
                     if (pos_w >= cnt_w) begin
                        status_in = ST_BOUND;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = req_pos;
                        state_in = S_READ;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SHIFT_UP: begin
            // read k-1 while writing k+1: never the same entry
            wr_en   = 1'b1;
            wr_addr = k_ff + IDX_W'(1);
            if (k_ff == pos_ff) begin
               state_in = S_INS_PUT;
            end else begin
               rd_en   = 1'b1;
               rd_addr = k_ff - IDX_W'(1);
               k_in    = k_ff - IDX_W'(1);
            end
         end
         S_INS_PUT: begin
            wr_en    = 1'b1;
            wr_addr  = pos_ff;
            wr_data  = val_ff;
            count_in = count_ff + CNT_W'(1);
            state_in = S_DONE;
         end
         S_SHIFT_DN: begin
            wr_en   = 1'b1;
            wr_addr = k_ff - IDX_W'(1);
            if (k_ff == cnt_last) begin
               count_in = count_m1;
               state_in = S_DONE;
            end else begin
               rd_en   = 1'b1;
               rd_addr = k_ff + IDX_W'(1);
               k_in    = k_ff + IDX_W'(1);
            end
         end
         S_SEARCH: begin
            if (rd_data_ff == val_ff) begin
               idx_in   = k_ff;
               state_in = S_DONE;
            end else if (k_ff == cnt_last) begin
               status_in = ST_NOTFOUND;
               state_in  = S_DONE;
            end else begin
               rd_en   = 1'b1;
               rd_addr = k_ff + IDX_W'(1);
               k_in    = k_ff + IDX_W'(1);
            end
         end
         S_READ: begin
            rdv_in   = rd_data_ff;
            state_in = S_DONE;
         end
         S_DONE: begin
            res_load = 1'b1;
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff      <= k_in;
      pos_ff    <= pos_in;
      val_ff    <= val_in;
      status_ff <= status_in;
      rdv_ff    <= rdv_in;
      idx_ff    <= idx_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= entry_mem[rd_addr];
      end
   end

   always_comb begin
      result.status      = status_ff;
      result.read_value  = VALUE_W'(rdv_ff);
      result.found_index = FIDX_W'(idx_ff);
      result.list_length = LEN_W'(count_ff);
   end

   ole_rsp_reg u_rsp_reg (
      .clock           (clock),
      .reset           (reset),
      .load            (res_load),
      .result          (result),
      .free            (rsp_free),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_read_value  (rsp_read_value),
      .rsp_found_index (rsp_found_index),
      .rsp_list_length (rsp_list_length)
   );

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("list length above capacity");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == S_DONE))
      else $error("response without a finished operation");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |->
         (count_ff == $past(count_ff) + CNT_W'(1) ||
          count_ff == $past(count_ff) - CNT_W'(1) || count_ff == '0))
      else $error("list length jumped");

   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEARCH || state_ff == S_SHIFT_DN) |-> (CNT_W'(k_ff) < count_ff))
      else $error("walk cursor past list end");

endmodule

>>> design/ole_rsp_reg.sv
// Response output register: holds one finished transaction until it is taken.
module ole_rsp_reg import ole_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       load,
   input  result_type                 result,
   output logic                       free,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic signed [VALUE_W-1:0]  rsp_read_value,
   output logic [FIDX_W-1:0]          rsp_found_index,
   output logic [LEN_W-1:0]           rsp_list_length
);

   logic       valid_ff;
   logic       valid_in;
   result_type data_ff;
   result_type data_in;

   assign free = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load && free) begin
         valid_in = 1'b1;
         data_in  = result;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_status      = data_ff.status;
   assign rsp_read_value  = data_ff.read_value;
   assign rsp_found_index = data_ff.found_index;
   assign rsp_list_length = data_ff.list_length;

endmodule

>>> tb/ordered_list_engine_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the ordered list engine: directed table, fill to capacity, then random traffic.
module ordered_list_engine_unit_tb;
   import ole_pkg::*;

   localparam int RANDOM_ITEMS = 1850;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int MAX_WAIT     = 17;
   localparam int DRAIN_CYCLES = 2 * CAPACITY + 8;
   localparam int N_ROWS       = 25;
   localparam int MAX_REPORTS  = 10;

   typedef struct packed {
      logic [REQ_W-1:0]          kind;
      logic [POS_W-1:0]          pos;
      logic signed [VALUE_W-1:0] value;
      logic                      has_exp;
      result_type                exp;
   } stim_row_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [REQ_W-1:0]          req_type = REQ_CLEAR;
   logic [POS_W-1:0]          req_position = '0;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [STATUS_W-1:0]       rsp_status;
   logic signed [VALUE_W-1:0] rsp_read_value;
   logic [FIDX_W-1:0]         rsp_found_index;
   logic [LEN_W-1:0]          rsp_list_length;

   logic signed [DATA_W-1:0] model_entries [CAPACITY];
   int                       model_len = 0;
   result_type               pending_results [$];
   int                       mismatches = 0;
   int                       cycles = 0;
   bit                       calm = 1'b0;

   logic signed [VALUE_W-1:0] value_pool [8] = '{
      32'sd0, 32'sd1, -32'sd1, 32'sh7FFFFFFF, 32'sh80000000, 32'sd42, -32'sd42, 32'sh55AA55AA
   };

   stim_row_type directed_rows [N_ROWS];

   ordered_list_engine_unit uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_type(req_type),
      .req_position(req_position),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_read_value(rsp_read_value),
      .rsp_found_index(rsp_found_index),
      .rsp_list_length(rsp_list_length)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic int draw_wait();
      if (calm || $urandom_range(0, 3) == 0)
         return 0;
      return $urandom_range(0, MAX_WAIT);
   endfunction

   function automatic logic signed [VALUE_W-1:0] pick_value();
      if ($urandom_range(0, 1) == 0)
         return value_pool[$urandom_range(0, 7)];
      return $urandom;
   endfunction

   // Applies one request to the shadow list and returns the transaction it must produce.
   function automatic result_type apply_list_request(logic [REQ_W-1:0] kind,
                                                      logic [POS_W-1:0] pos,
                                                      logic signed [VALUE_W-1:0] value);
      result_type r;
      int         k;
      r.status      = ST_OK;
      r.read_value  = '0;
      r.found_index = '0;
      case (kind)
         REQ_CLEAR: begin
            model_len = 0;
         end
         REQ_INSERT: begin
            if (pos > model_len)
               r.status = ST_BOUND;
            else if (model_len >= CAPACITY)
               r.status = ST_FULL;
            else begin
               for (k = model_len; k > pos; k--)
                  model_entries[k] = model_entries[k-1];
               model_entries[pos] = value;
               model_len++;
            end
         end
         REQ_REMOVE: begin
            if (pos >= model_len)
               r.status = ST_BOUND;
            else begin
               for (k = pos; k + 1 < model_len; k++)
                  model_entries[k] = model_entries[k+1];
               model_len--;
            end
         end
         REQ_SEARCH: begin
            r.status = ST_NOTFOUND;
            // walk downward so the lowest match is the one kept
            for (k = model_len - 1; k >= 0; k--) begin
               if (model_entries[k] == value) begin
                  r.status      = ST_OK;
                  r.found_index = FIDX_W'(k);
               end
            end
         end
         REQ_READ: begin
            if (pos >= model_len)
               r.status = ST_BOUND;
            else
               r.read_value = model_entries[pos];
         end
         default: begin
         end
      endcase
      r.list_length = LEN_W'(model_len);
      return r;
   endfunction

   task automatic send_request(input logic [REQ_W-1:0] kind, input logic [POS_W-1:0] pos,
                               input logic signed [VALUE_W-1:0] value,
                               input logic has_exp, input result_type exp);
      int         gap;
      result_type predicted;
      gap = draw_wait();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_type     <= kind;
      req_position <= pos;
      req_value    <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = apply_list_request(kind, pos, value);
      pending_results.push_back(has_exp ? exp : predicted);
   endtask

   task automatic report_mismatch(input string what, input result_type want,
                                  input result_type got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("%0t %s: expected st=%0d rd=%h idx=%0d len=%0d, got st=%0d rd=%h idx=%0d len=%0d",
                  $time, what, want.status, want.read_value, want.found_index,
                  want.list_length, got.status, got.read_value, got.found_index,
                  got.list_length);
   endtask

   // response side: random stall, then compare each transaction with the oldest expectation
   initial begin
      int         n;
      result_type got;
      result_type want;
      while (reset) @(posedge clock);
      forever begin
         n = draw_wait();
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         got.status      = rsp_status;
         got.read_value  = rsp_read_value;
         got.found_index = rsp_found_index;
         got.list_length = rsp_list_length;
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected transaction", '0, got);
         end else begin
            want = pending_results.pop_front();
            if (got.status !== want.status || got.read_value !== want.read_value ||
                got.found_index !== want.found_index || got.list_length !== want.list_length)
               report_mismatch("mismatch", want, got);
         end
      end
   end

   initial begin
      int                        i;
      int                        issued;
      int                        done;
      int                        pick;
      bit                        grow;
      logic [REQ_W-1:0]          kind;
      logic [POS_W-1:0]          pos;
      logic signed [VALUE_W-1:0] value;

      for (i = 0; i < CAPACITY; i++)
         model_entries[i] = '0;

      directed_rows = '{
         '{REQ_READ,   5'd0,  32'sd0,          1'b1, '{ST_BOUND,    32'sd0,        4'd0, 5'd0}},
         '{REQ_REMOVE, 5'd0,  32'sd0,          1'b1, '{ST_BOUND,    32'sd0,        4'd0, 5'd0}},
         '{REQ_SEARCH, 5'd0,  32'sd0,          1'b1, '{ST_NOTFOUND, 32'sd0,        4'd0, 5'd0}},
         '{REQ_INSERT, 5'd1,  32'sd7,          1'b1, '{ST_BOUND,    32'sd0,        4'd0, 5'd0}},
         '{REQ_INSERT, 5'd0,  32'sh7FFFFFFF,   1'b1, '{ST_OK,       32'sd0,        4'd0, 5'd1}},
         '{REQ_INSERT, 5'd0,  32'sh80000000,   1'b1, '{ST_OK,       32'sd0,        4'd0, 5'd2}},
         '{REQ_INSERT, 5'd2,  -32'sd1,         1'b1, '{ST_OK,       32'sd0,        4'd0, 5'd3}},
         '{REQ_INSERT, 5'd31, 32'sd5,          1'b1, '{ST_BOUND,    32'sd0,        4'd0, 5'd3}},
         '{REQ_READ,   5'd0,  32'sd0,          1'b1, '{ST_OK,       32'sh80000000, 4'd0, 5'd3}},
         '{REQ_READ,   5'd2,  32'sd0,          1'b1, '{ST_OK,       -32'sd1,       4'd0, 5'd3}},
         '{REQ_READ,   5'd3,  32'sd0,          1'b1, '{ST_BOUND,    32'sd0,        4'd0, 5'd3}},
         '{REQ_READ,   5'd31, 32'sd0,          1'b1, '{ST_BOUND,    32'sd0,        4'd0, 5'd3}},
         '{REQ_SEARCH, 5'd0,  -32'sd1,         1'b1, '{ST_OK,       32'sd0,        4'd2, 5'd3}},
         '{REQ_SEARCH, 5'd31, 32'sh7FFFFFFF,   1'b0, '0},
         '{REQ_SEARCH, 5'd0,  32'sd12345,      1'b1, '{ST_NOTFOUND, 32'sd0,        4'd0, 5'd3}},
         '{3'd5,       5'd31, -32'sd1,         1'b1, '{ST_OK,       32'sd0,        4'd0, 5'd3}},
         '{3'd7,       5'd0,  32'sd0,          1'b1, '{ST_OK,       32'sd0,        4'd0, 5'd3}},
         '{3'd6,       5'd16, 32'sh55AA55AA,   1'b0, '0},
         '{REQ_INSERT, 5'd1,  -32'sd1,         1'b0, '0},
         '{REQ_SEARCH, 5'd0,  -32'sd1,         1'b0, '0},
         '{REQ_REMOVE, 5'd0,  32'sd0,          1'b0, '0},
         '{REQ_REMOVE, 5'd31, 32'sd0,          1'b1, '{ST_BOUND,    32'sd0,        4'd0, 5'd3}},
         '{REQ_REMOVE, 5'd2,  32'sd0,          1'b0, '0},
         '{REQ_CLEAR,  5'd31, -32'sd1,         1'b1, '{ST_OK,       32'sd0,        4'd0, 5'd0}},
         '{REQ_READ,   5'd0,  32'sd0,          1'b1, '{ST_BOUND,    32'sd0,        4'd0, 5'd0}}
      };

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < N_ROWS; i++)
         send_request(directed_rows[i].kind, directed_rows[i].pos, directed_rows[i].value,
                      directed_rows[i].has_exp, directed_rows[i].exp);

      // fill to capacity, then the full and out-of-range inserts
      for (i = 0; i < CAPACITY; i++)
         send_request(REQ_INSERT, POS_W'($urandom_range(0, i)), pick_value(), 1'b0, '0);
      send_request(REQ_INSERT, 5'd0, 32'sd9, 1'b1, '{ST_FULL, 32'sd0, 4'd0, 5'd16});
      send_request(REQ_INSERT, 5'd17, 32'sd9, 1'b1, '{ST_BOUND, 32'sd0, 4'd0, 5'd16});
      send_request(REQ_READ, 5'd15, 32'sd0, 1'b0, '0);
      send_request(REQ_READ, 5'd16, 32'sd0, 1'b1, '{ST_BOUND, 32'sd0, 4'd0, 5'd16});
      send_request(REQ_REMOVE, 5'd15, 32'sd0, 1'b0, '0);

      issued = 0;
      done   = 0;
      grow   = 1'b0;
      while (done < RANDOM_ITEMS) begin
         if (issued % 150 == 0)
            calm = ($urandom_range(0, 3) == 0);
         if (issued % 60 == 0)
            grow = $urandom_range(0, 1);
         pick = $urandom_range(0, 99);
         if (pick < 1)
            kind = REQ_CLEAR;
         else if (pick < 4)
            kind = REQ_W'($urandom_range(5, 7));
         else if (grow)
            kind = (pick < 54) ? REQ_INSERT : (pick < 69) ? REQ_REMOVE :
                   (pick < 85) ? REQ_SEARCH : REQ_READ;
         else
            kind = (pick < 19) ? REQ_INSERT : (pick < 59) ? REQ_REMOVE :
                   (pick < 80) ? REQ_SEARCH : REQ_READ;

         if ($urandom_range(0, 9) == 0)
            pos = POS_W'($urandom_range(0, 31));
         else if (kind == REQ_INSERT)
            pos = POS_W'($urandom_range(0, model_len));
         else
            pos = POS_W'($urandom_range(0, (model_len == 0) ? 0 : model_len - 1));

         if (kind == REQ_SEARCH && model_len > 0 && $urandom_range(0, 9) < 6)
            value = model_entries[$urandom_range(0, model_len - 1)];
         else
            value = pick_value();

         send_request(kind, pos, value, 1'b0, '0);
         issued++;
         if (kind <= REQ_READ)
            done++;
      end

      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && pending_results.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
